/* rtl/core/bvm_pkg.sv */
// Package for the battery voltage monitor: constants, register codes and stage types.
`default_nettype none
package bvm_pkg;

    localparam int RAW_W  = 12;
    localparam int MV_W   = 13;
    localparam int PCT_W  = 7;
    localparam int ACC_W  = 16;
    localparam int CFG_W  = 13;
    localparam int ADDR_W = 2;
    localparam int X_W    = 24;

    localparam int SMOOTH_SHIFT_DEF = 3;

    localparam logic [RAW_W-1:0] ADC_FULL = 12'd4095;
    localparam logic [RAW_W-1:0] ADC_HALF = 12'd2047;
    localparam logic [RAW_W-1:0] REF_MV   = 12'd3300;

    localparam logic [MV_W-1:0] MV_MAX       = 13'h1FFF;
    localparam logic [MV_W-1:0] SOC_FULL_MV  = 13'd4100;
    localparam logic [MV_W-1:0] SOC_75_MV    = 13'd3950;
    localparam logic [MV_W-1:0] SOC_50_MV    = 13'd3750;
    localparam logic [MV_W-1:0] SOC_25_MV    = 13'd3550;
    localparam logic [MV_W-1:0] SOC_EMPTY_MV = 13'd3350;

    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
    localparam logic [PCT_W-1:0] PCT_75  = 7'd75;
    localparam logic [PCT_W-1:0] PCT_50  = 7'd50;
    localparam logic [PCT_W-1:0] PCT_25  = 7'd25;
    localparam logic [PCT_W-1:0] PCT_0   = 7'd0;

    localparam logic [CFG_W-1:0] LOW_ASSERT_RST  = 13'd3450;
    localparam logic [CFG_W-1:0] LOW_RELEASE_RST = 13'd3550;
    localparam logic [CFG_W-1:0] CRIT_ASSERT_RST = 13'd3350;
    localparam logic [CFG_W-1:0] CRIT_RELEASE_RST = 13'd3450;

    typedef enum logic [ADDR_W-1:0] {
        CFG_LOW_ASSERT   = 2'd0,
        CFG_LOW_RELEASE  = 2'd1,
        CFG_CRIT_ASSERT  = 2'd2,
        CFG_CRIT_RELEASE = 2'd3
    } t_cfg_idx;

    // scaled sample with uncorrected quotient
    typedef struct packed {
        logic             valid;
        logic             ok;
        logic             chg;
        logic [RAW_W-1:0] raw;
        logic [X_W-1:0]   x;
        logic [RAW_W-1:0] q0;
    } t_scale;

    // filtered sample
    typedef struct packed {
        logic             valid;
        logic             ok;
        logic             chg;
        logic [RAW_W-1:0] raw;
        logic [MV_W-1:0]  filt;
    } t_filt;

endpackage
`default_nettype wire

/* rtl/core/battery_voltage_monitor.sv */
// Battery voltage monitor top level: stream ports, config port and pipeline stall control.
// One item per cycle sustained while the result output is not stalled by i_m_tready.
// Pipeline: input register, scaling, filter update, status/result register.
// The whole pipeline advances together; a stalled result holds every stage.
// Reset (synchronous, active low) empties the pipeline, clears filter seed, latches
// and held values to zero and loads the threshold registers with their defaults.
`default_nettype none
module battery_voltage_monitor #(
    parameter int SMOOTH_SHIFT = bvm_pkg::SMOOTH_SHIFT_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_s_tvalid,
    output logic                         o_s_tready,
    input  wire  [15:0]                  i_s_tdata,   // [11:0] raw_sample, [15:12] zero
    input  wire  [1:0]                   i_s_tuser,   // [0] sample_ok, [1] charging
    output logic                         o_m_tvalid,
    input  wire                          i_m_tready,
    output logic [31:0]                  o_m_tdata,   // [11:0] last_raw, [24:12] battery_mv,
                                                      // [31:25] charge_percent
    output logic [3:0]                   o_m_tuser,   // [0] is_low, [1] is_critical,
                                                      // [2] reading_valid, [3] is_charging
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [bvm_pkg::ADDR_W-1:0]   i_cfg_addr,
    input  wire  [bvm_pkg::CFG_W-1:0]    i_cfg_data
);

    logic                      w_en;
    bvm_pkg::t_scale           w_scale;
    bvm_pkg::t_filt            w_filt;
    logic                      w_valid;
    logic [bvm_pkg::RAW_W-1:0] w_raw;
    logic [bvm_pkg::MV_W-1:0]  w_mv;
    logic [bvm_pkg::PCT_W-1:0] w_pct;
    logic                      w_low;
    logic                      w_crit;
    logic                      w_rd_valid;
    logic                      w_chg;

    assign w_en        = !w_valid || i_m_tready;
    assign o_s_tready  = w_en;
    assign o_cfg_ready = 1'b1;

    bvm_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_raw   (i_s_tdata[bvm_pkg::RAW_W-1:0]),
        .i_ok    (i_s_tuser[0]),
        .i_chg   (i_s_tuser[1]),
        .o_scale (w_scale)
    );

    bvm_filter #(
        .SMOOTH_SHIFT (SMOOTH_SHIFT)
    ) u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_scale (w_scale),
        .o_filt  (w_filt)
    );

    bvm_status u_status (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_filt     (w_filt),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_valid    (w_valid),
        .o_raw      (w_raw),
        .o_mv       (w_mv),
        .o_pct      (w_pct),
        .o_low      (w_low),
        .o_crit     (w_crit),
        .o_rd_valid (w_rd_valid),
        .o_chg      (w_chg)
    );

    assign o_m_tvalid = w_valid;
    assign o_m_tdata  = {w_pct, w_mv, w_raw};
    assign o_m_tuser  = {w_chg, w_rd_valid, w_crit, w_low};

endmodule
`default_nettype wire

/* rtl/core/bvm_scale.sv */
// Input register and converter-to-millivolt scaling with reciprocal quotient estimate.
`default_nettype none
module bvm_scale (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire                          i_valid,
    input  wire [bvm_pkg::RAW_W-1:0]     i_raw,
    input  wire                          i_ok,
    input  wire                          i_chg,
    output bvm_pkg::t_scale              o_scale
);

    logic                      r_valid;
    logic                      r_ok;
    logic                      r_chg;
    logic [bvm_pkg::RAW_W-1:0] r_raw;
    bvm_pkg::t_scale           r_scale;

    logic [bvm_pkg::X_W-1:0]   w_x;
    logic [35:0]               w_prod;

    // x / 4095 ~= x * 4097 / 2^24, low by at most one
    assign w_x    = bvm_pkg::X_W'(r_raw) * bvm_pkg::X_W'(bvm_pkg::REF_MV)
                  + bvm_pkg::X_W'(bvm_pkg::ADC_HALF);
    assign w_prod = 36'(w_x) + (36'(w_x) << 12);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_scale.valid <= 1'b0;
        end else if (i_en) begin
            r_valid       <= i_valid;
            r_scale.valid <= r_valid;
            r_raw         <= i_raw;
            r_ok          <= i_ok;
            r_chg         <= i_chg;
            r_scale.ok    <= r_ok;
            r_scale.chg   <= r_chg;
            r_scale.raw   <= r_raw;
            r_scale.x     <= w_x;
            r_scale.q0    <= w_prod[35:24];
        end
    end

    assign o_scale = r_scale;

endmodule
`default_nettype wire

/* rtl/core/bvm_filter.sv */
// Quotient correction, divider doubling and first-order IIR filter state.
`default_nettype none
module bvm_filter #(
    parameter int SMOOTH_SHIFT = bvm_pkg::SMOOTH_SHIFT_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  bvm_pkg::t_scale     i_scale,
    output bvm_pkg::t_filt      o_filt
);

    localparam int ACC_W  = bvm_pkg::ACC_W;
    localparam int SEED_W = ACC_W + SMOOTH_SHIFT;

    logic [ACC_W-1:0]          r_accum;
    logic                      r_seeded;
    bvm_pkg::t_filt            r_filt;

    logic [bvm_pkg::X_W-1:0]   w_rem;
    logic [bvm_pkg::RAW_W-1:0] w_q;
    logic [bvm_pkg::MV_W-1:0]  w_mv;
    logic [SEED_W-1:0]         w_seed;
    logic [ACC_W-1:0]          w_seed_sat;
    logic [ACC_W:0]            w_step;
    logic [ACC_W-1:0]          w_step_sat;
    logic [ACC_W-1:0]          w_accum_n;
    logic [ACC_W-1:0]          w_shr;
    logic [bvm_pkg::MV_W-1:0]  w_filt;
    logic                      w_upd;

    assign w_rem = i_scale.x - ((bvm_pkg::X_W'(i_scale.q0) << bvm_pkg::RAW_W)
                 - bvm_pkg::X_W'(i_scale.q0));
    assign w_q   = i_scale.q0
                 + bvm_pkg::RAW_W'(w_rem >= bvm_pkg::X_W'(bvm_pkg::ADC_FULL));
    assign w_mv  = {w_q, 1'b0};

    assign w_seed     = SEED_W'(w_mv) << SMOOTH_SHIFT;
    assign w_seed_sat = (w_seed[SEED_W-1:ACC_W] != '0) ? '1 : w_seed[ACC_W-1:0];

    assign w_step     = {1'b0, r_accum} - (ACC_W+1)'(r_accum >> SMOOTH_SHIFT)
                      + (ACC_W+1)'(w_mv);
    assign w_step_sat = w_step[ACC_W] ? '1 : w_step[ACC_W-1:0];

    assign w_accum_n = r_seeded ? w_step_sat : w_seed_sat;
    assign w_shr     = w_accum_n >> SMOOTH_SHIFT;
    assign w_filt    = (w_shr > ACC_W'(bvm_pkg::MV_MAX)) ? bvm_pkg::MV_MAX
                                                        : w_shr[bvm_pkg::MV_W-1:0];

    assign w_upd = i_en && i_scale.valid && i_scale.ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded     <= 1'b0;
            r_accum      <= '0;
            r_filt.valid <= 1'b0;
        end else begin
            if (w_upd) begin
                r_seeded <= 1'b1;
                r_accum  <= w_accum_n;
            end
            if (i_en) begin
                r_filt.valid <= i_scale.valid;
                r_filt.ok    <= i_scale.ok;
                r_filt.chg   <= i_scale.chg;
                r_filt.raw   <= i_scale.raw;
                r_filt.filt  <= w_filt;
            end
        end
    end

    assign o_filt = r_filt;

endmodule
`default_nettype wire

/* rtl/core/bvm_status.sv */
// Threshold registers, hysteresis latches, charge percent and held result register.
`default_nettype none
module bvm_status (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  bvm_pkg::t_filt               i_filt,
    input  wire                          i_cfg_we,
    input  wire [bvm_pkg::ADDR_W-1:0]    i_cfg_addr,
    input  wire [bvm_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                         o_valid,
    output logic [bvm_pkg::RAW_W-1:0]    o_raw,
    output logic [bvm_pkg::MV_W-1:0]     o_mv,
    output logic [bvm_pkg::PCT_W-1:0]    o_pct,
    output logic                         o_low,
    output logic                         o_crit,
    output logic                         o_rd_valid,
    output logic                         o_chg
);

    logic [bvm_pkg::CFG_W-1:0] r_low_asrt;
    logic [bvm_pkg::CFG_W-1:0] r_low_rel;
    logic [bvm_pkg::CFG_W-1:0] r_crit_asrt;
    logic [bvm_pkg::CFG_W-1:0] r_crit_rel;

    logic                      r_valid;
    logic [bvm_pkg::RAW_W-1:0] r_raw;
    logic [bvm_pkg::MV_W-1:0]  r_mv;
    logic [bvm_pkg::PCT_W-1:0] r_pct;
    logic                      r_low;
    logic                      r_crit;
    logic                      r_rd_valid;
    logic                      r_chg;

    logic                      n_low;
    logic                      n_crit;
    logic [bvm_pkg::PCT_W-1:0] n_pct;
    logic [bvm_pkg::MV_W-1:0]  w_d75;
    logic [bvm_pkg::MV_W-1:0]  w_d50;
    logic [bvm_pkg::MV_W-1:0]  w_d25;
    logic [bvm_pkg::MV_W-1:0]  w_d0;
    logic [15:0]               w_d75x;

    // d / 6 as d * 171 >> 10, exact for d < 150
    assign w_d75  = i_filt.filt - bvm_pkg::SOC_75_MV;
    assign w_d75x = 16'(w_d75[7:0]) * 16'd171;
    assign w_d50  = i_filt.filt - bvm_pkg::SOC_50_MV;
    assign w_d25  = i_filt.filt - bvm_pkg::SOC_25_MV;
    assign w_d0   = i_filt.filt - bvm_pkg::SOC_EMPTY_MV;

    always_comb begin
        if (i_filt.filt >= bvm_pkg::SOC_FULL_MV) begin
            n_pct = bvm_pkg::PCT_MAX;
        end else if (i_filt.filt >= bvm_pkg::SOC_75_MV) begin
            n_pct = bvm_pkg::PCT_75 + bvm_pkg::PCT_W'(w_d75x[15:10]);
        end else if (i_filt.filt >= bvm_pkg::SOC_50_MV) begin
            n_pct = bvm_pkg::PCT_50 + bvm_pkg::PCT_W'(w_d50[7:3]);
        end else if (i_filt.filt >= bvm_pkg::SOC_25_MV) begin
            n_pct = bvm_pkg::PCT_25 + bvm_pkg::PCT_W'(w_d25[7:3]);
        end else if (i_filt.filt >= bvm_pkg::SOC_EMPTY_MV) begin
            n_pct = bvm_pkg::PCT_0 + bvm_pkg::PCT_W'(w_d0[7:3]);
        end else begin
            n_pct = bvm_pkg::PCT_0;
        end
    end

    assign n_low  = r_low  ? (i_filt.filt < r_low_rel)  : (i_filt.filt <= r_low_asrt);
    assign n_crit = r_crit ? (i_filt.filt < r_crit_rel) : (i_filt.filt <= r_crit_asrt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_asrt  <= bvm_pkg::LOW_ASSERT_RST;
            r_low_rel   <= bvm_pkg::LOW_RELEASE_RST;
            r_crit_asrt <= bvm_pkg::CRIT_ASSERT_RST;
            r_crit_rel  <= bvm_pkg::CRIT_RELEASE_RST;
        end else if (i_cfg_we) begin
            case (bvm_pkg::t_cfg_idx'(i_cfg_addr))
                bvm_pkg::CFG_LOW_ASSERT:   r_low_asrt  <= i_cfg_data;
                bvm_pkg::CFG_LOW_RELEASE:  r_low_rel   <= i_cfg_data;
                bvm_pkg::CFG_CRIT_ASSERT:  r_crit_asrt <= i_cfg_data;
                bvm_pkg::CFG_CRIT_RELEASE: r_crit_rel  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_raw      <= '0;
            r_mv       <= '0;
            r_pct      <= '0;
            r_low      <= 1'b0;
            r_crit     <= 1'b0;
            r_rd_valid <= 1'b0;
            r_chg      <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_filt.valid;
            if (i_filt.valid) begin
                r_chg <= i_filt.chg;
                if (i_filt.ok) begin
                    r_raw      <= i_filt.raw;
                    r_mv       <= i_filt.filt;
                    r_pct      <= n_pct;
                    r_low      <= n_low;
                    r_crit     <= n_crit;
                    r_rd_valid <= 1'b1;
                end
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_raw      = r_raw;
    assign o_mv       = r_mv;
    assign o_pct      = r_pct;
    assign o_low      = r_low;
    assign o_crit     = r_crit;
    assign o_rd_valid = r_rd_valid;
    assign o_chg      = r_chg;

endmodule
`default_nettype wire
